// ===== rtl/usr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package usr_pkg;

    // Default sizes of the chunk buffer and of one packet's payload.
    localparam int unsigned USR_CHUNK_BYTES     = 4096;
    localparam int unsigned USR_MAX_PACKET_DATA = 1024;

    // Payload widths; the tdata widths are rounded up to whole bytes.
    localparam int unsigned IN_TDATA_W  = 96;
    localparam int unsigned IN_TUSER_W  = 4;
    localparam int unsigned OUT_TDATA_W = 72;
    localparam int unsigned OUT_TUSER_W = 1;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MAX_IMAGE_BYTES    = 2'd0,
        CFG_SESSION_TIMEOUT    = 2'd1,
        CFG_DUPLICATE_INTERVAL = 2'd2,
        CFG_ACK_WINDOW         = 2'd3
    } cfg_idx_t;

    localparam logic [31:0] RST_MAX_IMAGE_BYTES    = 32'd1048576;
    localparam logic [31:0] RST_SESSION_TIMEOUT    = 32'd5000000;
    localparam logic [31:0] RST_DUPLICATE_INTERVAL = 32'd200000;
    localparam logic [7:0]  RST_ACK_WINDOW         = 8'd8;

    // Event kinds carried by an input item.
    typedef enum logic [2:0] {
        MODE_BEGIN = 3'd0,
        MODE_DATA  = 3'd1,
        MODE_END   = 3'd2,
        MODE_TICK  = 3'd3,
        MODE_FAIL  = 3'd4,
        MODE_DONE  = 3'd5,
        MODE_NOTE  = 3'd6
    } mode_t;

    // Session phase.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RECV = 2'd1,
        PH_DONE = 2'd2,
        PH_FAIL = 2'd3
    } phase_t;

    // Status codes; other values come straight from fail items.
    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_BUSY    = 4'd1;
    localparam logic [3:0] ST_BADHDR  = 4'd2;
    localparam logic [3:0] ST_SEQ     = 4'd3;
    localparam logic [3:0] ST_SIZE    = 4'd4;
    localparam logic [3:0] ST_TIMEOUT = 4'd5;

    typedef struct packed {
        logic [31:0] max_image_bytes;
        logic [31:0] session_timeout;
        logic [31:0] duplicate_interval;
        logic [7:0]  ack_window;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] announced_size;
        logic [15:0] packet_seq;
        logic [10:0] data_bytes;
        logic        too_short;
        logic        window_last;
        logic [31:0] time_now;
        logic [3:0]  fail_reason;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  session_state;
        logic [3:0]  status_code;
        logic [15:0] expected_seq;
        logic [31:0] bytes_received;
        logic        send_reply;
        logic        transfer_finished;
        logic        is_busy;
        logic        flush_request;
        logic [12:0] flush_length;
        logic        last_result;
    } result_t;

    // What one processed item hands to the output queue.
    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } commit_t;

endpackage

`default_nettype wire

// ===== rtl/update_session_receiver_core.sv =====
// Path: an accepted item is registered in the input register, and its results
// are registered in the result queue, from which the m_ side takes them.
// Throughput: one item per cycle while the result queue has room for both of
// an item's results; a four-entry result queue absorbs output stalls.
// Reset: synchronous, active low on aresetn; it clears the session state,
// empties the queue and restores the configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module update_session_receiver_core import usr_pkg::*; #(
    parameter int unsigned CHUNK_BYTES     = USR_CHUNK_BYTES,
    parameter int unsigned MAX_PACKET_DATA = USR_MAX_PACKET_DATA
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    // Input items.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // announced_size[31:0], packet_seq[47:32], data_bytes[58:48],
    // time_now[90:59], fail_reason[94:91], zero pad[95]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // mode[2:0], too_short[3]
    input  wire logic [IN_TUSER_W-1:0]  s_tuser,
    // window_last
    input  wire logic                   s_tlast,

    // Result items.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // session_state[1:0], status_code[5:2], expected_seq[21:6],
    // bytes_received[53:22], send_reply[54], transfer_finished[55],
    // is_busy[56], flush_length[69:57], zero pad[71:70]
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // flush_request[0]
    output logic [OUT_TUSER_W-1:0]      m_tuser,
    // last_result
    output logic                        m_tlast,

    // Configuration writes.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // The input register holds one item; the engine processes it once it is
    // registered, as soon as the result queue can take both results.
    logic       in_valid_reg, in_valid_next;
    in_item_t   in_item_reg;
    in_item_t   in_item;
    cfg_t       cfg_reg, cfg_next;
    logic       room;
    logic       fire;
    logic       s_accept;
    commit_t    commit;
    result_t    head;

    assign fire      = in_valid_reg && room;
    assign s_tready  = !in_valid_reg || room;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Unpack the stream payload into the item's fields.
    always_comb begin
        in_item.mode           = s_tuser[2:0];
        in_item.too_short      = s_tuser[3];
        in_item.window_last    = s_tlast;
        in_item.announced_size = s_tdata[31:0];
        in_item.packet_seq     = s_tdata[47:32];
        in_item.data_bytes     = s_tdata[58:48];
        in_item.time_now       = s_tdata[90:59];
        in_item.fail_reason    = s_tdata[94:91];
    end

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= in_item;
        end
    end

    // Configuration registers; the ack window keeps only its low byte.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_MAX_IMAGE_BYTES:    cfg_next.max_image_bytes    = cfg_data;
                CFG_SESSION_TIMEOUT:    cfg_next.session_timeout    = cfg_data;
                CFG_DUPLICATE_INTERVAL: cfg_next.duplicate_interval = cfg_data;
                CFG_ACK_WINDOW:         cfg_next.ack_window         = cfg_data[7:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_image_bytes    <= RST_MAX_IMAGE_BYTES;
            cfg_reg.session_timeout    <= RST_SESSION_TIMEOUT;
            cfg_reg.duplicate_interval <= RST_DUPLICATE_INTERVAL;
            cfg_reg.ack_window         <= RST_ACK_WINDOW;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Session bookkeeping: compares and adds on the session registers, which
    // update at the same edge the item's results enter the queue.
    usr_engine #(
        .CHUNK_BYTES     (CHUNK_BYTES),
        .MAX_PACKET_DATA (MAX_PACKET_DATA)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .commit  (commit)
    );

    // Result queue: a flush result and its status result enter together.
    usr_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fire ? commit : '0),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (head)
    );

    assign m_tdata = {2'b00, head.flush_length, head.is_busy, head.transfer_finished,
                      head.send_reply, head.bytes_received, head.expected_seq,
                      head.status_code, head.session_state};
    assign m_tuser = head.flush_request;
    assign m_tlast = head.last_result;

endmodule

`default_nettype wire

// ===== rtl/usr_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module usr_engine import usr_pkg::*; #(
    parameter int unsigned CHUNK_BYTES     = USR_CHUNK_BYTES,
    parameter int unsigned MAX_PACKET_DATA = USR_MAX_PACKET_DATA
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     fire,
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output commit_t       commit
);

    localparam int unsigned FW = $clog2(CHUNK_BYTES);
    localparam int unsigned TW = $clog2(CHUNK_BYTES + 2048);
    localparam int unsigned K  = $clog2(MAX_PACKET_DATA / CHUNK_BYTES + 2);
    localparam int unsigned RW = TW + K;
    localparam logic [16:0] CHUNK_W        = 17'(CHUNK_BYTES);
    localparam logic [12:0] FULL_FLUSH_LEN = CHUNK_W[12:0];
    localparam logic [12:0] MAX_DATA_W     = 13'(MAX_PACKET_DATA);

    phase_t        phase_reg, phase_next;
    logic [3:0]    code_reg, code_next;
    logic [15:0]   want_seq_reg, want_seq_next;
    logic [31:0]   got_reg, got_next;
    logic [31:0]   target_reg, target_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [7:0]    since_ack_reg, since_ack_next;
    logic          dup_rep_reg, dup_rep_next;
    logic [31:0]   dup_time_reg, dup_time_next;
    logic          ended_reg, ended_next;
    logic [31:0]   last_act_reg, last_act_next;

    logic [RW-1:0] total;
    logic [RW-1:0] rem;
    logic          flushed;
    logic          overrun;
    logic          oversize;
    logic          report;
    logic          timed_out;
    logic [7:0]    since_inc;
    logic [16:0]   fill_wide;
    logic [12:0]   pend_len;

    logic          has_status;
    logic          has_flush;
    logic          reply;
    logic          fin;
    logic [12:0]   flen;
    result_t       status_res;
    result_t       flush_res;

    // Fill arithmetic: the remainder modulo the chunk size is found by K
    // conditional subtractions of shifted chunk sizes.
    always_comb begin
        total = RW'(fill_reg) + RW'(item.data_bytes);
        rem   = total;
        for (int k = int'(K) - 1; k >= 0; k--) begin
            if (rem >= (RW'(CHUNK_BYTES) << k)) begin
                rem = rem - (RW'(CHUNK_BYTES) << k);
            end
        end
    end

    assign flushed   = total >= RW'(CHUNK_BYTES);
    assign overrun   = ({1'b0, got_reg} + 33'(item.data_bytes)) > {1'b0, target_reg};
    assign oversize  = 13'(item.data_bytes) > MAX_DATA_W;
    assign report    = !dup_rep_reg ||
                       ((item.time_now - dup_time_reg) >= cfg.duplicate_interval);
    assign timed_out = (item.time_now - last_act_reg) > cfg.session_timeout;
    assign since_inc = since_ack_reg + 8'd1;
    assign fill_wide = 17'(fill_reg);
    assign pend_len  = fill_wide[12:0];

    always_comb begin
        phase_next     = phase_reg;
        code_next      = code_reg;
        want_seq_next  = want_seq_reg;
        got_next       = got_reg;
        target_next    = target_reg;
        fill_next      = fill_reg;
        since_ack_next = since_ack_reg;
        dup_rep_next   = dup_rep_reg;
        dup_time_next  = dup_time_reg;
        ended_next     = ended_reg;
        last_act_next  = last_act_reg;
        has_status     = 1'b1;
        has_flush      = 1'b0;
        reply          = 1'b1;
        fin            = 1'b0;
        flen           = '0;

        unique case (item.mode)
            MODE_BEGIN: begin
                if (phase_reg == PH_RECV || phase_reg == PH_DONE) begin
                    code_next = ST_BUSY;
                end else if (item.announced_size == 32'd0 ||
                             item.announced_size > cfg.max_image_bytes) begin
                    phase_next = PH_FAIL;
                    code_next  = ST_BADHDR;
                    fill_next  = '0;
                    ended_next = 1'b0;
                end else begin
                    phase_next     = PH_RECV;
                    code_next      = ST_OK;
                    want_seq_next  = '0;
                    got_next       = '0;
                    target_next    = item.announced_size;
                    fill_next      = '0;
                    since_ack_next = '0;
                    dup_rep_next   = 1'b0;
                    dup_time_next  = '0;
                    ended_next     = 1'b0;
                    last_act_next  = item.time_now;
                end
            end
            MODE_DATA: begin
                if (phase_reg != PH_RECV || ended_reg) begin
                    code_next = ST_BADHDR;
                end else begin
                    last_act_next = item.time_now;
                    if (item.too_short) begin
                        code_next = ST_SEQ;
                    end else if (oversize) begin
                        code_next = ST_BADHDR;
                    end else if (item.packet_seq != want_seq_reg) begin
                        code_next = ST_SEQ;
                        reply     = report;
                        if (report) begin
                            dup_rep_next  = 1'b1;
                            dup_time_next = item.time_now;
                        end
                    end else if (overrun) begin
                        phase_next = PH_FAIL;
                        code_next  = ST_SIZE;
                        fill_next  = '0;
                        ended_next = 1'b0;
                    end else begin
                        fill_next     = rem[FW-1:0];
                        got_next      = got_reg + 32'(item.data_bytes);
                        want_seq_next = want_seq_reg + 16'd1;
                        code_next     = ST_OK;
                        dup_rep_next  = 1'b0;
                        dup_time_next = '0;
                        if (item.window_last || since_inc >= cfg.ack_window) begin
                            since_ack_next = '0;
                            reply          = 1'b1;
                        end else begin
                            since_ack_next = since_inc;
                            reply          = 1'b0;
                        end
                        has_flush = flushed;
                        flen      = FULL_FLUSH_LEN;
                    end
                end
            end
            MODE_END: begin
                if (phase_reg != PH_RECV || ended_reg) begin
                    code_next = ST_BADHDR;
                end else begin
                    last_act_next = item.time_now;
                    if (got_reg != target_reg) begin
                        phase_next = PH_FAIL;
                        code_next  = ST_SIZE;
                        fill_next  = '0;
                        ended_next = 1'b0;
                    end else begin
                        fill_next  = '0;
                        ended_next = 1'b1;
                        code_next  = ST_OK;
                        reply      = 1'b0;
                        fin        = 1'b1;
                        has_flush  = fill_reg != '0;
                        flen       = pend_len;
                    end
                end
            end
            MODE_TICK: begin
                reply = 1'b0;
                if (phase_reg == PH_RECV && !ended_reg && timed_out) begin
                    phase_next = PH_FAIL;
                    code_next  = ST_TIMEOUT;
                    fill_next  = '0;
                    ended_next = 1'b0;
                end
            end
            MODE_FAIL: begin
                phase_next = PH_FAIL;
                code_next  = item.fail_reason;
                fill_next  = '0;
                ended_next = 1'b0;
            end
            MODE_DONE: begin
                phase_next = PH_DONE;
                code_next  = ST_OK;
                fill_next  = '0;
                ended_next = 1'b0;
            end
            MODE_NOTE: begin
                has_status = 1'b0;
                if (phase_reg == PH_RECV) begin
                    last_act_next = item.time_now;
                end
            end
            default: begin
                has_status = 1'b0;
            end
        endcase
    end

    // Both results of an item show the session as it stands after the item.
    always_comb begin
        status_res.session_state     = phase_next;
        status_res.status_code       = code_next;
        status_res.expected_seq      = want_seq_next;
        status_res.bytes_received    = got_next;
        status_res.send_reply        = reply;
        status_res.transfer_finished = fin;
        status_res.is_busy           = phase_next == PH_RECV || phase_next == PH_DONE;
        status_res.flush_request     = 1'b0;
        status_res.flush_length      = '0;
        status_res.last_result       = 1'b1;

        flush_res                   = status_res;
        flush_res.send_reply        = 1'b0;
        flush_res.transfer_finished = 1'b0;
        flush_res.flush_request     = 1'b1;
        flush_res.flush_length      = flen;
        flush_res.last_result       = 1'b0;

        commit.first  = has_flush ? flush_res : status_res;
        commit.second = status_res;
        if (!has_status) begin
            commit.num = 2'd0;
        end else if (has_flush) begin
            commit.num = 2'd2;
        end else begin
            commit.num = 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            code_reg      <= ST_OK;
            want_seq_reg  <= '0;
            got_reg       <= '0;
            target_reg    <= '0;
            fill_reg      <= '0;
            since_ack_reg <= '0;
            dup_rep_reg   <= 1'b0;
            dup_time_reg  <= '0;
            ended_reg     <= 1'b0;
            last_act_reg  <= '0;
        end else if (fire) begin
            phase_reg     <= phase_next;
            code_reg      <= code_next;
            want_seq_reg  <= want_seq_next;
            got_reg       <= got_next;
            target_reg    <= target_next;
            fill_reg      <= fill_next;
            since_ack_reg <= since_ack_next;
            dup_rep_reg   <= dup_rep_next;
            dup_time_reg  <= dup_time_next;
            ended_reg     <= ended_next;
            last_act_reg  <= last_act_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/usr_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module usr_out_fifo import usr_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire commit_t push,
    output logic         room,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_item
);

    result_t     mem_reg [4];
    logic [2:0]  count_reg, count_next;
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic        pop;

    // Room for a whole item's results, whatever leaves this cycle.
    assign room      = count_reg <= 3'd2;
    assign out_valid = count_reg != 3'd0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next  = count_reg + 3'(push.num) - 3'(pop);
        wr_ptr_next = wr_ptr_reg + push.num;
        rd_ptr_next = rd_ptr_reg + 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            mem_reg[wr_ptr_reg + 2'd1] <= push.second;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/usr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module usr_checker import usr_pkg::*; (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata,
    input wire logic [OUT_TUSER_W-1:0] m_tuser,
    input wire logic                   m_tlast
);

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    // A flush result is never the last result of its item.
    a_flush_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tlast)
        else $error("flush result marked last");

    // The status result follows a flush result without a gap.
    a_flush_then_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser[0] |=> m_tvalid && m_tlast)
        else $error("status result missing after flush");

    // A finished transfer is reported only while the session is receiving.
    a_finish_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[55] |-> m_tlast && m_tdata[1:0] == PH_RECV)
        else $error("transfer finished outside a receiving session");

endmodule

bind update_session_receiver_core usr_checker u_usr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
